FILE: hw/rtl/assert_macros.svh
// shared assertion helpers, sampled on clk and idle while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dptc_pkg;

    // utf-8 lead and continuation classes
    localparam logic [7:0] UTF8_LEAD2_MASK = 8'he0;
    localparam logic [7:0] UTF8_LEAD2_CODE = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3_MASK = 8'hf0;
    localparam logic [7:0] UTF8_LEAD3_CODE = 8'he0;
    localparam logic [7:0] UTF8_LEAD4_MASK = 8'hf8;
    localparam logic [7:0] UTF8_LEAD4_CODE = 8'hf0;
    localparam logic [7:0] UTF8_CONT_MASK  = 8'hc0;
    localparam logic [7:0] UTF8_CONT_CODE  = 8'h80;

    // code point limits
    localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
    localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;
    localparam logic [20:0] CP_MAX        = 21'h10ffff;
    localparam logic [9:0]  CP_SURR_BLOCK = 10'h01b;   // bits 20:11 of 0xd800..0xdfff

    // sequence length classes (continuations expected)
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // template characters
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_QUERY  = 8'h3f;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // matcher progress through the dns variable
    localparam logic [2:0] MATCH_IDLE  = 3'd0;
    localparam logic [2:0] MATCH_BRACE = 3'd1;
    localparam logic [2:0] MATCH_OPER  = 3'd2;
    localparam logic [2:0] MATCH_D     = 3'd3;
    localparam logic [2:0] MATCH_N     = 3'd4;
    localparam logic [2:0] MATCH_S     = 3'd5;

    // byte position, saturating
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_REST   = 2'd2;

    typedef struct packed {
        logic ok;
    } utf8_status_t;

    typedef struct packed {
        logic prefix_failed;
        logic fragment_seen;
        logic variable_found;
    } tmpl_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dptc_utf8.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dptc_utf8 (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        step,
    input  wire                        last,
    input  wire [7:0]                  data_byte,
    output dptc_pkg::utf8_status_t     status
);

    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  cls_reg, cls_next;
    logic [20:0] acc_reg, acc_next;
    logic        fail_reg, fail_next;
    logic [20:0] cp;
    logic        cp_bad;

    assign cp = {acc_reg[14:0], data_byte[5:0]};

    always_comb
    begin
        cp_bad = (cls_reg == dptc_pkg::SEQ_THREE && cp < dptc_pkg::CP_MIN_3BYTE)
              || (cls_reg == dptc_pkg::SEQ_FOUR && cp < dptc_pkg::CP_MIN_4BYTE)
              || (cp > dptc_pkg::CP_MAX)
              || (cp[20:11] == dptc_pkg::CP_SURR_BLOCK);
    end

    always_comb
    begin
        pend_next = pend_reg;
        cls_next  = cls_reg;
        acc_next  = acc_reg;
        fail_next = fail_reg;
        if (pend_reg == 2'd0)
        begin
            if (!data_byte[7])
            begin
                // plain ascii
            end
            else if ((data_byte & dptc_pkg::UTF8_LEAD2_MASK) == dptc_pkg::UTF8_LEAD2_CODE)
            begin
                // c0 and c1 are always overlong
                if (data_byte[4:0] < 5'd2)
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    cls_next  = dptc_pkg::SEQ_TWO;
                    pend_next = dptc_pkg::SEQ_TWO;
                    acc_next  = {16'd0, data_byte[4:0]};
                end
            end
            else if ((data_byte & dptc_pkg::UTF8_LEAD3_MASK) == dptc_pkg::UTF8_LEAD3_CODE)
            begin
                cls_next  = dptc_pkg::SEQ_THREE;
                pend_next = dptc_pkg::SEQ_THREE;
                acc_next  = {17'd0, data_byte[3:0]};
            end
            else if ((data_byte & dptc_pkg::UTF8_LEAD4_MASK) == dptc_pkg::UTF8_LEAD4_CODE)
            begin
                cls_next  = dptc_pkg::SEQ_FOUR;
                pend_next = dptc_pkg::SEQ_FOUR;
                acc_next  = {18'd0, data_byte[2:0]};
            end
            else
            begin
                fail_next = 1'b1;
            end
        end
        else if ((data_byte & dptc_pkg::UTF8_CONT_MASK) != dptc_pkg::UTF8_CONT_CODE)
        begin
            fail_next = 1'b1;
            pend_next = 2'd0;
        end
        else
        begin
            acc_next  = cp;
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1 && cp_bad)
            begin
                fail_next = 1'b1;
            end
        end
    end

    assign status.ok = !fail_next && (pend_next == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            cls_reg  <= dptc_pkg::SEQ_NONE;
            acc_reg  <= 21'd0;
            fail_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                pend_reg <= 2'd0;
                cls_reg  <= dptc_pkg::SEQ_NONE;
                acc_reg  <= 21'd0;
                fail_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= pend_next;
                cls_reg  <= cls_next;
                acc_reg  <= acc_next;
                fail_reg <= fail_next;
            end
        end
    end

    `ASSERT_NEXT(a_utf8_clear_after_last, step && last, pend_reg == 2'd0 && !fail_reg, "utf-8 state not cleared after last byte")
    `ASSERT_SAME(a_utf8_pend_within_class, 1'b1, pend_reg <= cls_reg, "pending continuations exceed sequence class")

endmodule

`default_nettype wire

FILE: hw/rtl/dptc_tmpl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dptc_tmpl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        step,
    input  wire                        last,
    input  wire [7:0]                  data_byte,
    output dptc_pkg::tmpl_status_t     status
);

    logic [1:0] pos_reg, pos_next;
    logic       pfail_reg, pfail_next;
    logic       frag_reg, frag_next;
    logic [2:0] match_reg, match_next;
    logic       found_reg, found_next;
    logic       hit;

    always_comb
    begin
        case (match_reg)
            dptc_pkg::MATCH_IDLE:  hit = (data_byte == dptc_pkg::CH_LBRACE);
            dptc_pkg::MATCH_BRACE: hit = (data_byte == dptc_pkg::CH_QUERY)
                                      || (data_byte == dptc_pkg::CH_AMP);
            dptc_pkg::MATCH_OPER:  hit = (data_byte == dptc_pkg::CH_D);
            dptc_pkg::MATCH_D:     hit = (data_byte == dptc_pkg::CH_N);
            dptc_pkg::MATCH_N:     hit = (data_byte == dptc_pkg::CH_S);
            dptc_pkg::MATCH_S:     hit = (data_byte == dptc_pkg::CH_RBRACE);
            default:               hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pfail_next = pfail_reg;
        frag_next  = frag_reg || (data_byte == dptc_pkg::CH_HASH);
        found_next = found_reg;
        pos_next   = pos_reg;
        if (pos_reg == dptc_pkg::POS_FIRST && data_byte != dptc_pkg::CH_SLASH)
        begin
            pfail_next = 1'b1;
        end
        if (pos_reg == dptc_pkg::POS_SECOND && data_byte == dptc_pkg::CH_SLASH)
        begin
            pfail_next = 1'b1;
        end
        if (pos_reg != dptc_pkg::POS_REST)
        begin
            pos_next = pos_reg + 2'd1;
        end

        // a miss on '{' restarts the match one character in
        if (hit && match_reg == dptc_pkg::MATCH_S)
        begin
            found_next = 1'b1;
            match_next = dptc_pkg::MATCH_IDLE;
        end
        else if (hit)
        begin
            match_next = match_reg + 3'd1;
        end
        else if (data_byte == dptc_pkg::CH_LBRACE)
        begin
            match_next = dptc_pkg::MATCH_BRACE;
        end
        else
        begin
            match_next = dptc_pkg::MATCH_IDLE;
        end
    end

    assign status.prefix_failed  = pfail_next;
    assign status.fragment_seen  = frag_next;
    assign status.variable_found = found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= dptc_pkg::POS_FIRST;
            pfail_reg <= 1'b0;
            frag_reg  <= 1'b0;
            match_reg <= dptc_pkg::MATCH_IDLE;
            found_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                pos_reg   <= dptc_pkg::POS_FIRST;
                pfail_reg <= 1'b0;
                frag_reg  <= 1'b0;
                match_reg <= dptc_pkg::MATCH_IDLE;
                found_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                pfail_reg <= pfail_next;
                frag_reg  <= frag_next;
                match_reg <= match_next;
                found_reg <= found_next;
            end
        end
    end

    `ASSERT_NEXT(a_tmpl_clear_after_last, step && last, pos_reg == dptc_pkg::POS_FIRST && match_reg == dptc_pkg::MATCH_IDLE, "template state not cleared after last byte")
    `ASSERT_SAME(a_tmpl_match_range, 1'b1, match_reg <= dptc_pkg::MATCH_S && pos_reg <= dptc_pkg::POS_REST, "matcher or position out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/doh_path_template_check_unit.sv
// doh path template check
// input stream: one byte of the path template value per transaction,
// s_axis_tdata[7:0] is the byte and s_axis_tlast marks the last byte of the value
// output stream: one transaction per value, issued for the last byte,
// m_axis_tdata[0] template_ok, m_axis_tdata[1] utf8_ok, upper bits zero
// an accepted byte is held in the input register and updates the utf-8 and
// template state from there; the verdict of a last byte then passes into the
// output register, which drives the output transaction
// throughput is one byte per cycle unless a last byte is held back
// the state clears itself after each last byte, ready for the next value
// reset (rst_n low, asynchronous) empties both registers and clears all state
// when the receiver stalls, non-last bytes still flow; a last byte waits in the
// input register until the output register is free, and s_axis_tready drops
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module doh_path_template_check_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,     // [7:0] data_byte
    input  wire        s_axis_tlast,     // final_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata      // [0] template_ok, [1] utf8_ok, [7:2] zero
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic                   out_tok_reg;
    logic                   out_uok_reg;
    logic                   advance;
    logic                   tok;
    dptc_pkg::utf8_status_t utf8_status;
    dptc_pkg::tmpl_status_t tmpl_status;

    // only a last byte needs room in the output register
    assign advance = in_valid_reg
                  && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    dptc_utf8 u_utf8 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .last      (in_last_reg),
        .data_byte (in_byte_reg),
        .status    (utf8_status)
    );

    dptc_tmpl u_tmpl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .last      (in_last_reg),
        .data_byte (in_byte_reg),
        .status    (tmpl_status)
    );

    assign tok = utf8_status.ok && !tmpl_status.prefix_failed
              && !tmpl_status.fragment_seen && tmpl_status.variable_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_tok_reg <= tok;
            out_uok_reg <= utf8_status.ok;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_uok_reg, out_tok_reg};

    `ASSERT_SAME(a_top_result_from_last, $rose(out_valid_reg), $past(advance && in_last_reg), "result issued without a last byte")
    `ASSERT_SAME(a_top_tok_needs_uok, out_valid_reg, !(out_tok_reg && !out_uok_reg), "template verdict passed on bad utf-8")

endmodule

`default_nettype wire
